/* src/sra_pkg.sv */
// Shared widths, register codes and control types for the sparse row accumulator.
// No dependencies; imported by sra_accum, sparse_row_accumulator, sra_checker and the testbench.
`timescale 1ns / 1ps

package sra_pkg;

	localparam int COLS_DEF   = 64;
	localparam int COL_W      = 32;
	localparam int VAL_W      = 16;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int SUM_W      = 48;
	localparam int POS_W      = 6;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COL_BASE   = 1'b0,
		REG_COUNT_ONLY = 1'b1
	} cfg_reg_t;

	localparam logic REQ_ACC = 1'b0;
	localparam logic REQ_END = 1'b1;

	// accumulate request toward the sum store
	typedef struct packed {
		logic en;
		logic fresh;
	} acc_ctl_t;

endpackage

/* src/sra_accum.sv */
// Column sum store with multiply / read-modify-write pipeline and a drain read port.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_accum #(
	parameter int COLS = sra_pkg::COLS_DEF,
	parameter int SW   = $clog2(COLS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sra_pkg::acc_ctl_t                  acc,
	input  logic [SW-1:0]                      acc_slot,
	input  logic signed [sra_pkg::VAL_W-1:0]   b_value,
	input  logic signed [sra_pkg::VAL_W-1:0]   c_value,
	input  logic                               rd_en,
	input  logic [SW-1:0]                      rd_slot,
	output logic [sra_pkg::SUM_W-1:0]          rd_data
);
	import sra_pkg::*;

	logic [SUM_W-1:0] sums_mem [COLS];
	logic [SUM_W-1:0] rdata_q;

	logic                     en_s1;
	logic                     fresh_s1;
	logic [SW-1:0]            slot_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic             wr_vld_q;
	logic [SW-1:0]    wr_slot_q;
	logic [SUM_W-1:0] wr_data_q;

	logic [SW-1:0]    rd_addr;
	logic [SUM_W-1:0] base;
	logic [SUM_W-1:0] sum_new;

	assign rd_addr = rd_en ? rd_slot : acc_slot;

	// first touch of a row starts from zero; a write on the same edge as our read is forwarded
	always_comb begin
		if (fresh_s1) begin
			base = '0;
		end else if (wr_vld_q && wr_slot_q == slot_s1) begin
			base = wr_data_q;
		end else begin
			base = rdata_q;
		end
		sum_new = base + SUM_W'(prod_s1);
	end

	always_ff @(posedge clk) begin
		if (acc.en || rd_en) begin
			rdata_q <= sums_mem[rd_addr];
		end
		if (en_s1) begin
			sums_mem[slot_s1] <= sum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1    <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			en_s1    <= acc.en;
			wr_vld_q <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc.en) begin
			fresh_s1 <= acc.fresh;
			slot_s1  <= acc_slot;
			prod_s1  <= PROD_W'(b_value) * PROD_W'(c_value);
		end
		if (en_s1) begin
			wr_slot_q <= slot_s1;
			wr_data_q <= sum_new;
		end
	end

	assign rd_data = rdata_q;

endmodule

/* src/sparse_row_accumulator.sv */
// Sparse row accumulator: top level with touch marks, order store, drain sequencer, output beat.
// Depends on sra_pkg and sra_accum.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  config   | cfg_we                 | cfg_index, cfg_wdata
//  input    | in_valid / in_ready    | req_type, column, b_value, c_value
//  output   | out_valid / out_ready  | out_column, sum, position, row_count, is_last,
//           |                        | is_empty, range_error
//
// Product beats are taken one per cycle while no row is draining; the sum store registers
// the product and the stored sum, then adds and writes back, forwarding back-to-back hits on
// one column. An end-of-row beat blocks input until the row is out: each touched column
// passes through order store read, sum store read and output load, an empty or count-only
// row only through output load, and output stalls hold either. The result register lets input
// resume while the last beat waits. Reset clears marks, count and flags at once; no clearing pass.
`timescale 1ns / 1ps

module sparse_row_accumulator #(
	parameter int COLS = sra_pkg::COLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sra_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [sra_pkg::COL_W-1:0]            column,
	input  logic signed [sra_pkg::VAL_W-1:0]     b_value,
	input  logic signed [sra_pkg::VAL_W-1:0]     c_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sra_pkg::COL_W-1:0]            out_column,
	output logic signed [sra_pkg::SUM_W-1:0]     sum,
	output logic [sra_pkg::POS_W-1:0]            position,
	output logic [sra_pkg::CNT_W-1:0]            row_count,
	output logic                                 is_last,
	output logic                                 is_empty,
	output logic                                 range_error
);
	import sra_pkg::*;

	localparam int SW = $clog2(COLS);
	localparam int KW = $clog2(COLS + 1);

	typedef enum logic [2:0] {
		ST_ACC,
		ST_SINGLE,
		ST_RD_ORDER,
		ST_RD_SUM,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [COL_W-1:0] col_base_q;
	logic             count_only_q;

	logic [COLS-1:0] marks_q;
	logic [KW-1:0]   count_q;
	logic            oow_q;
	logic [KW-1:0]   k_q;

	logic [SW-1:0] order_mem [COLS];
	logic [SW-1:0] ord_rd_q;

	logic             out_valid_q;
	logic [COL_W-1:0] out_column_q;
	logic [SUM_W-1:0] sum_q;
	logic [POS_W-1:0] position_q;
	logic [CNT_W-1:0] row_count_q;
	logic             is_last_q;
	logic             is_empty_q;
	logic             range_error_q;

	logic [COL_W-1:0] offset;
	logic             in_window;
	logic [SW-1:0]    slot_in;
	logic             fire;
	logic             acc_fire;
	logic             end_fire;
	logic             fresh;
	logic             out_free;
	logic             out_load;
	logic             last_k;
	acc_ctl_t         acc;
	logic             rd_en;
	logic [SUM_W-1:0] rd_data;

	assign offset    = column - col_base_q;
	assign in_window = offset < COL_W'(COLS);
	assign slot_in   = offset[SW-1:0];
	assign in_ready  = (state_q == ST_ACC);
	assign fire      = in_valid && in_ready;
	assign acc_fire  = fire && req_type == REQ_ACC && in_window;
	assign end_fire  = fire && req_type == REQ_END;
	assign fresh     = !marks_q[slot_in];
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && (state_q == ST_SINGLE || state_q == ST_EMIT);
	assign last_k    = (k_q + KW'(1)) == count_q;
	assign rd_en     = (state_q == ST_RD_SUM);

	assign acc.en    = acc_fire;
	assign acc.fresh = fresh;

	sra_accum #(
		.COLS (COLS),
		.SW   (SW)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.acc_slot (slot_in),
		.b_value  (b_value),
		.c_value  (c_value),
		.rd_en    (rd_en),
		.rd_slot  (ord_rd_q),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_base_q   <= '0;
			count_only_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COL_BASE:   col_base_q   <= cfg_wdata[COL_W-1:0];
				REG_COUNT_ONLY: count_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// first-touch order list
	always_ff @(posedge clk) begin
		if (acc_fire && fresh) begin
			order_mem[count_q[SW-1:0]] <= slot_in;
		end
		if (state_q == ST_RD_ORDER) begin
			ord_rd_q <= order_mem[k_q[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_ACC;
			marks_q       <= '0;
			count_q       <= '0;
			oow_q         <= 1'b0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			out_column_q  <= '0;
			sum_q         <= '0;
			position_q    <= '0;
			row_count_q   <= '0;
			is_last_q     <= 1'b0;
			is_empty_q    <= 1'b0;
			range_error_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACC: begin
					if (acc_fire && fresh) begin
						marks_q[slot_in] <= 1'b1;
						count_q          <= count_q + KW'(1);
					end
					if (fire && req_type == REQ_ACC && !in_window) begin
						oow_q <= 1'b1;
					end
					if (end_fire) begin
						k_q <= '0;
						if (count_q == '0 || count_only_q) begin
							state_q <= ST_SINGLE;
						end else begin
							state_q <= ST_RD_ORDER;
						end
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						out_column_q  <= '0;
						sum_q         <= '0;
						position_q    <= '0;
						row_count_q   <= CNT_W'(count_q);
						is_last_q     <= 1'b1;
						is_empty_q    <= 1'b1;
						range_error_q <= oow_q;
						marks_q       <= '0;
						count_q       <= '0;
						oow_q         <= 1'b0;
						state_q       <= ST_ACC;
					end
				end
				ST_RD_ORDER: state_q <= ST_RD_SUM;
				ST_RD_SUM:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_column_q  <= col_base_q + COL_W'(ord_rd_q);
						sum_q         <= rd_data;
						position_q    <= POS_W'(k_q);
						row_count_q   <= CNT_W'(count_q);
						is_last_q     <= last_k;
						is_empty_q    <= 1'b0;
						range_error_q <= oow_q;
						if (last_k) begin
							marks_q <= '0;
							count_q <= '0;
							oow_q   <= 1'b0;
							state_q <= ST_ACC;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= ST_RD_ORDER;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_column  = out_column_q;
	assign sum         = sum_q;
	assign position    = position_q;
	assign row_count   = row_count_q;
	assign is_last     = is_last_q;
	assign is_empty    = is_empty_q;
	assign range_error = range_error_q;

	a_marks_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(marks_q) == int'(count_q))
		else $error("touch marks disagree with touched count");

	a_drain_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_ORDER || state_q == ST_RD_SUM || state_q == ST_EMIT)
		|-> (k_q < count_q))
		else $error("drain index beyond touched count");

	a_end_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		end_fire |=> !in_ready)
		else $error("input taken during row drain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= KW'(COLS))
		else $error("touched count exceeds column window");

endmodule

/* sim/sra_checker.sv */
// Result checker for the sparse row accumulator: watches config writes and both beat channels,
// predicts each row's output beats and compares them field by field.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_checker #(
	parameter int COLS = sra_pkg::COLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sra_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [sra_pkg::COL_W-1:0]            column,
	input  logic signed [sra_pkg::VAL_W-1:0]     b_value,
	input  logic signed [sra_pkg::VAL_W-1:0]     c_value,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [sra_pkg::COL_W-1:0]            out_column,
	input  logic signed [sra_pkg::SUM_W-1:0]     sum,
	input  logic [sra_pkg::POS_W-1:0]            position,
	input  logic [sra_pkg::CNT_W-1:0]            row_count,
	input  logic                                 is_last,
	input  logic                                 is_empty,
	input  logic                                 range_error,
	output int                                   errors,
	output int                                   pending
);
	import sra_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [SUM_W-1:0] total;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
		logic             last;
		logic             empty;
		logic             rerr;
	} row_beat_t;

	row_beat_t        row_beats_due[$];
	logic             touched[COLS];
	logic [SUM_W-1:0] col_sum[COLS];
	logic [POS_W-1:0] first_touch[COLS];
	int unsigned      n_touched;
	logic             dropped;
	logic [COL_W-1:0] base;
	logic             cnt_mode;

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		logic [COL_W-1:0]         slot;
		logic signed [PROD_W-1:0] prod;
		logic [POS_W-1:0]         s;
		row_beat_t                want;
		if (!arst_n) begin
			for (int i = 0; i < COLS; i++) begin
				touched[i] = 1'b0;
				col_sum[i] = '0;
				first_touch[i] = '0;
			end
			n_touched = 0;
			dropped = 1'b0;
			base = '0;
			cnt_mode = 1'b0;
			row_beats_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (row_beats_due.size() == 0) begin
					$error("result beat with nothing expected: out_column %0h sum %0h",
						out_column, sum);
					errors++;
				end else begin
					want = row_beats_due.pop_front();
					check_field("out_column", 64'(want.col), 64'(out_column));
					check_field("sum", 64'(want.total), 64'($unsigned(sum)));
					check_field("position", 64'(want.pos), 64'(position));
					check_field("row_count", 64'(want.cnt), 64'(row_count));
					check_field("is_last", 64'(want.last), 64'(is_last));
					check_field("is_empty", 64'(want.empty), 64'(is_empty));
					check_field("range_error", 64'(want.rerr), 64'(range_error));
				end
			end

			if (in_valid && in_ready) begin
				if (req_type == REQ_ACC) begin
					slot = column - base;
					if (slot >= COLS) begin
						dropped = 1'b1;
					end else begin
						if (!touched[slot]) begin
							touched[slot] = 1'b1;
							first_touch[n_touched] = slot[POS_W-1:0];
							n_touched++;
						end
						prod = PROD_W'(b_value) * PROD_W'(c_value);
						col_sum[slot] = col_sum[slot] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
					end
				end else begin
					if (n_touched == 0 || cnt_mode) begin
						// empty row and count-only row both give a single flagged beat
						want = '0;
						want.cnt = n_touched[CNT_W-1:0];
						want.last = 1'b1;
						want.empty = 1'b1;
						want.rerr = dropped;
						row_beats_due.push_back(want);
					end else begin
						for (int k = 0; k < n_touched; k++) begin
							s = first_touch[k];
							want = '0;
							want.col = base + COL_W'(s);
							want.total = col_sum[s];
							want.pos = k[POS_W-1:0];
							want.cnt = n_touched[CNT_W-1:0];
							want.last = (k == n_touched - 1);
							want.rerr = dropped;
							row_beats_due.push_back(want);
						end
					end
					for (int k = 0; k < n_touched; k++) begin
						touched[first_touch[k]] = 1'b0;
						col_sum[first_touch[k]] = '0;
					end
					n_touched = 0;
					dropped = 1'b0;
				end
			end

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_COL_BASE:   base = cfg_wdata;
					REG_COUNT_ONLY: cnt_mode = cfg_wdata[0];
				endcase
			end
			pending = row_beats_due.size();
		end
	end

endmodule

/* sim/sparse_row_accumulator_test.sv */
// Testbench top for sparse_row_accumulator: drives config writes and product/end-of-row beats,
// applies random source gaps and sink stalls, and reports the verdict from sra_checker.
// Depends on sra_pkg, sra_checker and the block RTL.
`timescale 1ns / 1ps

module sparse_row_accumulator_test;
	import sra_pkg::*;

	localparam int SLOTS      = COLS_DEF;
	localparam int LIMIT      = 2_000_000;
	localparam int SETTLE     = 8;
	localparam int DRAIN_WAIT = 50;
	localparam int PHASE_BEATS = 30;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	logic                    in_valid;
	logic                    in_ready;
	logic                    req_type;
	logic [COL_W-1:0]        column;
	logic signed [VAL_W-1:0] b_value;
	logic signed [VAL_W-1:0] c_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [COL_W-1:0]        out_column;
	logic signed [SUM_W-1:0] sum;
	logic [POS_W-1:0]        position;
	logic [CNT_W-1:0]        row_count;
	logic                    is_last;
	logic                    is_empty;
	logic                    range_error;

	int          errors;
	int          pending;
	int unsigned cycles;
	int unsigned beats_sent;
	bit          tx_steady;
	bit          rx_steady;
	logic [31:0] cur_base;

	sparse_row_accumulator dut (.*);
	sra_checker row_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// sink side: random stall before each result beat, none while rx_steady is set
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// entered and left at a falling edge; valid stays up when the next beat follows at once
	task automatic send_beat(input logic rt, input logic [31:0] col, input logic [15:0] b,
			input logic [15:0] c);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		column <= col;
		b_value <= b;
		c_value <= c;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic product(input int unsigned slot);
		send_beat(REQ_ACC, cur_base + slot, 16'($urandom), 16'($urandom));
	endtask

	task automatic end_row();
		send_beat(REQ_END, $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] new_base, input logic new_count_only);
		logic [31:0] junk;
		settle();
		junk = $urandom;
		junk[0] = new_count_only;
		cfg_we <= 1'b1;
		cfg_index <= REG_COL_BASE;
		cfg_wdata <= new_base;
		@(negedge clk);
		cfg_index <= REG_COUNT_ONLY;
		cfg_wdata <= junk;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_base = new_base;
	endtask

	task automatic random_row(input bit sweep);
		int unsigned perm[SLOTS];
		int unsigned hot[4];
		int unsigned kind;
		int unsigned len;
		int unsigned j;
		int unsigned t;
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		kind = sweep ? 1 : $urandom_range(0, 19);
		if (kind == 1) begin
			// every slot once in shuffled order, then some repeats
			foreach (perm[i]) perm[i] = i;
			for (int i = SLOTS - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			foreach (perm[i]) product(perm[i]);
			repeat (8) product($urandom_range(0, SLOTS - 1));
		end else if (kind != 0) begin
			foreach (hot[i]) hot[i] = $urandom_range(0, SLOTS - 1);
			len = $urandom_range(1, kind < 6 ? 24 : 8);
			repeat (len) begin
				case ($urandom_range(0, 7))
					0: begin
						// outside the window: anywhere, or just past either end
						case ($urandom_range(0, 2))
							0: send_beat(REQ_ACC, $urandom, 16'($urandom), 16'($urandom));
							1: send_beat(REQ_ACC, cur_base + SLOTS, 16'($urandom),
								16'($urandom));
							default: send_beat(REQ_ACC, cur_base - 32'd1, 16'($urandom),
								16'($urandom));
						endcase
					end
					1, 2, 3: product(hot[$urandom_range(0, 3)]);
					default: product($urandom_range(0, SLOTS - 1));
				endcase
			end
		end
		end_row();
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		logic [31:0] phase_base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COL_BASE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_ACC;
		column = '0;
		b_value = '0;
		c_value = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		cur_base = '0;
		beats_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty row, value extremes, out-of-window columns, count-only rows
		end_row();
		send_beat(REQ_ACC, 32'd0, 16'h8000, 16'h8000);
		send_beat(REQ_ACC, 32'd63, 16'h7fff, 16'h8000);
		send_beat(REQ_ACC, 32'd64, 16'h7fff, 16'h7fff);
		send_beat(REQ_ACC, 32'hffff_ffff, 16'h8000, 16'h8000);
		send_beat(REQ_ACC, 32'd0, 16'h7fff, 16'h7fff);
		send_beat(REQ_ACC, 32'd5, 16'hffff, 16'h0001);
		end_row();
		send_beat(REQ_ACC, 32'h8000_0000, 16'h1234, 16'h5678);
		end_row();
		set_regs(32'd0, 1'b1);
		send_beat(REQ_ACC, 32'd7, 16'h0003, 16'hfffd);
		send_beat(REQ_ACC, 32'd7, 16'h0100, 16'h0100);
		send_beat(REQ_ACC, 32'd9, 16'h8000, 16'h7fff);
		end_row();
		end_row();
		send_beat(REQ_ACC, 32'd100, 16'h0001, 16'h0001);
		end_row();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: phase_base = 32'hffff_ffe0;
				1: phase_base = 32'hffff_ffff;
				3: phase_base = 32'd0;
				4: phase_base = 32'hffff_ffc0;
				default: phase_base = $urandom;
			endcase
			set_regs(phase_base, p == 2 || p == 4);
			phase_start = beats_sent;
			if (p % 3 == 0)
				random_row(1'b1);
			while (beats_sent - phase_start < PHASE_BEATS)
				random_row(1'b0);
		end

		settle();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sparse_row_accumulator.f */
src/sra_pkg.sv
src/sra_accum.sv
src/sparse_row_accumulator.sv
sim/sra_checker.sv
sim/sparse_row_accumulator_test.sv
